[rtl/lmf_pkg.sv]
package lmf_pkg;

  // Field widths
  localparam int CmdW       = 2;
  localparam int CoordW     = 4;
  localparam int RowW       = 16;
  localparam int IntensityW = 4;
  localparam int CountW     = 9;
  localparam int WordW      = 16;

  // Frame store: 16 entries, each one half-row (two module lines, 16 pixels)
  localparam int Entries = 16;
  localparam int AddrW   = $clog2(Entries);
  localparam int PosW    = $clog2(RowW);

  // Refresh sequence: 15 chip-select groups of 4 words
  localparam int WordsPerGroup = 4;
  localparam int Groups        = 15;
  localparam int RefreshWords  = Groups * WordsPerGroup;
  localparam int WordIdxW      = $clog2(RefreshWords);
  localparam int GroupW        = WordIdxW - $clog2(WordsPerGroup);

  localparam logic [WordIdxW-1:0] LastWord = WordIdxW'(RefreshWords - 1);
  localparam logic [CountW-1:0]   AllLit   = CountW'(Entries * RowW);

  // Group numbers in the refresh sequence
  localparam logic [GroupW-1:0] GrpDigitFirst = GroupW'(1);
  localparam logic [GroupW-1:0] GrpDigitLast  = GroupW'(8);
  localparam logic [GroupW-1:0] GrpDecode     = GroupW'(9);
  localparam logic [GroupW-1:0] GrpIntensity  = GroupW'(10);
  localparam logic [GroupW-1:0] GrpScanLimit  = GroupW'(11);
  localparam logic [GroupW-1:0] GrpTest       = GroupW'(12);
  localparam logic [GroupW-1:0] GrpShutdown   = GroupW'(13);

  // Setup words of the driver chips
  localparam logic [WordW-1:0] WordNoop      = 16'h0000;
  localparam logic [WordW-1:0] WordDecode    = 16'h0900;
  localparam logic [WordW-1:0] WordIntensity = 16'h0A00;
  localparam logic [WordW-1:0] WordScanLimit = 16'h0B07;
  localparam logic [WordW-1:0] WordTest      = 16'h0F00;
  localparam logic [WordW-1:0] WordShutdown  = 16'h0C01;

  localparam logic [IntensityW-1:0] IntensityReset = 4'h1;

  typedef enum logic [CmdW-1:0] {
    CMD_SET_PIXEL = 2'd0,
    CMD_FILL      = 2'd1,
    CMD_ROW_WRITE = 2'd2,
    CMD_REFRESH   = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REFRESH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic                capture;    // latch input fields, read their entry
    logic                exec;       // do the pixel/fill/row operation
    logic                refresh;    // refresh sequence running
    logic                emit;       // load one refresh word into the output
    logic [WordIdxW-1:0] word_idx;
    logic [WordIdxW-1:0] word_idx_nxt;
  } lmf_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } lmf_sts_t;

  // Entry holding row y: line y&7, upper modules for the top half
  function automatic logic [AddrW-1:0] row_entry(input logic [CoordW-1:0] y);
    return {y[2:0], ~y[3]};
  endfunction

  // Bit of pixel column x inside an entry; leftmost pixel in bit 7 of each byte
  function automatic logic [PosW-1:0] pix_pos(input logic [CoordW-1:0] x);
    return {x[3], ~x[2:0]};
  endfunction

  // Row pattern (bit x = column x) to entry bit order
  function automatic logic [RowW-1:0] row_to_entry(input logic [RowW-1:0] row);
    logic [RowW-1:0] e;
    e = '0;
    for (int i = 0; i < RowW; i++) begin
      e[pix_pos(CoordW'(i))] = row[i];
    end
    return e;
  endfunction

  // Entry read for refresh word n: byte n-4, two bytes per entry
  function automatic logic [AddrW-1:0] word_entry(input logic [WordIdxW-1:0] n);
    logic [WordIdxW-2:0] half;
    half = n[WordIdxW-1:1] - (WordIdxW-1)'(2);
    return half[AddrW-1:0];
  endfunction

  function automatic logic [4:0] pop16(input logic [RowW-1:0] v);
    logic [4:0] s;
    s = '0;
    for (int i = 0; i < RowW / 4; i++) begin
      s = s + 5'(v[4*i]) + 5'(v[4*i+1]) + 5'(v[4*i+2]) + 5'(v[4*i+3]);
    end
    return s;
  endfunction

  // Serial word for position n of the refresh sequence
  function automatic logic [WordW-1:0] refresh_word(input logic [WordIdxW-1:0] n,
                                                    input logic [7:0] data,
                                                    input logic [IntensityW-1:0] inten);
    logic [GroupW-1:0] g;
    logic [WordW-1:0]  w;
    g = n[WordIdxW-1:WordIdxW-GroupW];
    case (g) inside
      [GrpDigitFirst:GrpDigitLast]: w = {(8-GroupW)'(0), g, data};
      GrpDecode:    w = WordDecode;
      GrpIntensity: w = WordIntensity | WordW'(inten);
      GrpScanLimit: w = WordScanLimit;
      GrpTest:      w = WordTest;
      GrpShutdown:  w = WordShutdown;
      default:      w = WordNoop;
    endcase
    return w;
  endfunction

endpackage

[rtl/lmf_if.sv]
// Command channel
interface lmf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  x;
  logic [3:0]  y;
  logic        on;
  logic [15:0] row_bits;

  modport source (output valid, cmd, x, y, on, row_bits, input ready);
  modport sink   (input valid, cmd, x, y, on, row_bits, output ready);
endinterface

// Result channel
interface lmf_out_if;
  logic        valid;
  logic        ready;
  logic        old_pixel;
  logic [8:0]  lit_count;
  logic [15:0] serial_word;
  logic        group_end;
  logic        last;

  modport source (output valid, old_pixel, lit_count, serial_word, group_end, last,
                  input ready);
  modport sink   (input valid, old_pixel, lit_count, serial_word, group_end, last,
                  output ready);
endinterface

[rtl/led_matrix_framebuffer_refresh.sv]
// Framebuffer and refresh sequencer for a 16x16 display of four cascaded
// 8x8 LED matrix drivers.
// in_chan (valid/ready) takes commands: set pixel, fill, row write, refresh.
// out_chan (valid/ready) returns results: one for set pixel, fill and row
// write (last=1), sixty serial words for refresh, group_end on every fourth,
// last on the final one. Every result carries the current lit-pixel count.
// cfg_we/cfg_wdata write the 4-bit intensity; write it only while idle.
// After a command is transferred, the controller enters its execute or
// refresh state and loads each result into the output register once it is
// free. Set pixel, fill and row write: accept, then a read-modify-write of
// one frame-store entry. Refresh: one word per cycle while out_chan is not
// stalled, the frame-store read one word ahead of the output register.
// A stalled receiver holds the result in the output register; the sequencer
// waits and resumes the cycle out_chan.ready returns. A new command can be
// taken while the last result of the previous one is still waiting.
// Reset (rst_n low, synchronous) clears the picture to dark, the lit count
// to zero and the intensity to 1; no clearing pass is needed.
module led_matrix_framebuffer_refresh (
  input  logic                           clk,
  input  logic                           rst_n,
  lmf_in_if.sink                         in_chan,
  lmf_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [lmf_pkg::IntensityW-1:0] cfg_wdata
);
  import lmf_pkg::*;

  lmf_ctl_t ctl;
  lmf_sts_t sts;

  lmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_cmd   (in_chan.cmd),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lmf_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_chan.cmd),
    .in_x            (in_chan.x),
    .in_y            (in_chan.y),
    .in_on           (in_chan.on),
    .in_row_bits     (in_chan.row_bits),
    .ctl             (ctl),
    .sts             (sts),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_old_pixel   (out_chan.old_pixel),
    .out_lit_count   (out_chan.lit_count),
    .out_serial_word (out_chan.serial_word),
    .out_group_end   (out_chan.group_end),
    .out_last        (out_chan.last)
  );

endmodule

[rtl/lmf_ctrl.sv]
module lmf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_cmd,
  output logic             in_ready,
  input  lmf_pkg::lmf_sts_t sts,
  output lmf_pkg::lmf_ctl_t ctl
);
  import lmf_pkg::*;

  state_t              state_r, state_nxt;
  logic [WordIdxW-1:0] cnt_r, cnt_nxt;

  // State and word counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    in_ready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.exec    = 1'b0;
    ctl.refresh = 1'b0;
    ctl.emit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          cnt_nxt     = '0;
          if (cmd_e_t'(in_cmd) == CMD_REFRESH) state_nxt = ST_REFRESH;
          else                                 state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          ctl.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_REFRESH: begin
        ctl.refresh = 1'b1;
        if (sts.out_free) begin
          ctl.emit = 1'b1;
          if (cnt_r == LastWord) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + WordIdxW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    ctl.word_idx     = cnt_r;
    ctl.word_idx_nxt = cnt_nxt;
  end

endmodule

[rtl/lmf_datapath.sv]
module lmf_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lmf_pkg::IntensityW-1:0]      cfg_wdata,
  input  logic [lmf_pkg::CmdW-1:0]            in_cmd,
  input  logic [lmf_pkg::CoordW-1:0]          in_x,
  input  logic [lmf_pkg::CoordW-1:0]          in_y,
  input  logic                                in_on,
  input  logic [lmf_pkg::RowW-1:0]            in_row_bits,
  input  lmf_pkg::lmf_ctl_t                   ctl,
  output lmf_pkg::lmf_sts_t                   sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_old_pixel,
  output logic [lmf_pkg::CountW-1:0]          out_lit_count,
  output logic [lmf_pkg::WordW-1:0]           out_serial_word,
  output logic                                out_group_end,
  output logic                                out_last
);
  import lmf_pkg::*;

  // Frame store: one entry per half-row, bytes of two adjacent modules
  logic [RowW-1:0]       mem [Entries];
  logic [Entries-1:0]    valid_r;
  logic                  fill_r;
  logic [RowW-1:0]       rd_data_r;
  logic                  rd_valid_r;
  logic [AddrW-1:0]      rd_addr;

  logic [IntensityW-1:0] intensity_r;
  logic [CountW-1:0]     lit_r, lit_nxt;

  cmd_e_t                cmd_r;
  logic [CoordW-1:0]     x_r, y_r;
  logic                  on_r;
  logic [RowW-1:0]       row_r;

  logic                  out_valid_r;
  logic                  old_pixel_r, group_end_r, last_r;
  logic [CountW-1:0]     lit_count_r;
  logic [WordW-1:0]      serial_word_r;

  logic [RowW-1:0]       cur, pix_mask, row_mask, wr_data;
  logic [PosW-1:0]       pos;
  logic                  old_pix;
  logic                  wr_en;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n)      intensity_r <= IntensityReset;
    else if (cfg_we) intensity_r <= cfg_wdata;
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= cmd_e_t'(in_cmd);
      x_r   <= in_x;
      y_r   <= in_y;
      on_r  <= in_on;
      row_r <= in_row_bits;
    end
  end

  // Read address: new item, refresh word ahead of the counter, or held item
  always_comb begin
    if (ctl.capture)      rd_addr = row_entry(in_y);
    else if (ctl.refresh) rd_addr = word_entry(ctl.word_idx_nxt);
    else                  rd_addr = row_entry(y_r);
  end

  // Memory with registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) mem[row_entry(y_r)] <= wr_data;
  end

  // Entry valid bits; an unwritten entry reads as the last fill value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fill_r     <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[rd_addr];
      if (ctl.exec && cmd_r == CMD_FILL) begin
        valid_r <= '0;
        fill_r  <= on_r;
      end else if (wr_en) begin
        valid_r[row_entry(y_r)] <= 1'b1;
      end
    end
  end

  assign cur = rd_valid_r ? rd_data_r : {RowW{fill_r}};

  // Pixel and row update
  assign pos      = pix_pos(x_r);
  assign pix_mask = RowW'(1) << pos;
  assign old_pix  = cur[pos];
  assign row_mask = row_to_entry(row_r);
  assign wr_en    = ctl.exec && (cmd_r == CMD_SET_PIXEL || cmd_r == CMD_ROW_WRITE);

  always_comb begin
    wr_data = cur | row_mask;
    lit_nxt = lit_r;
    case (cmd_r)
      CMD_SET_PIXEL: begin
        wr_data = on_r ? (cur | pix_mask) : (cur & ~pix_mask);
        if (on_r && !old_pix)      lit_nxt = lit_r + CountW'(1);
        else if (!on_r && old_pix) lit_nxt = lit_r - CountW'(1);
      end
      CMD_FILL:      lit_nxt = on_r ? AllLit : '0;
      CMD_ROW_WRITE: lit_nxt = lit_r + CountW'(pop16(row_mask & ~cur));
      default:       lit_nxt = lit_r;
    endcase
  end

  // Lit-pixel counter
  always_ff @(posedge clk) begin
    if (!rst_n)        lit_r <= '0;
    else if (ctl.exec) lit_r <= lit_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n)                        out_valid_r <= 1'b0;
    else if (ctl.exec || ctl.emit)     out_valid_r <= 1'b1;
    else if (out_ready)                out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      old_pixel_r   <= (cmd_r == CMD_SET_PIXEL) ? old_pix : 1'b0;
      lit_count_r   <= lit_nxt;
      serial_word_r <= WordNoop;
      group_end_r   <= 1'b0;
      last_r        <= 1'b1;
    end else if (ctl.emit) begin
      old_pixel_r   <= 1'b0;
      lit_count_r   <= lit_r;
      serial_word_r <= refresh_word(ctl.word_idx,
                                    ctl.word_idx[0] ? cur[15:8] : cur[7:0],
                                    intensity_r);
      group_end_r   <= (ctl.word_idx[1:0] == 2'd3);
      last_r        <= (ctl.word_idx == LastWord);
    end
  end

  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_old_pixel   = old_pixel_r;
  assign out_lit_count   = lit_count_r;
  assign out_serial_word = serial_word_r;
  assign out_group_end   = group_end_r;
  assign out_last        = last_r;

endmodule

[rtl/lmf_checker.sv]
module lmf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_old_pixel,
  input logic [8:0]  out_lit_count,
  input logic [15:0] out_serial_word,
  input logic        out_group_end,
  input logic        out_last
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_serial_word)
      && $stable(out_last) && $stable(out_lit_count))
    else $error("result changed while stalled");

  // Never more lit pixels than the panel has
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lit_count <= 9'd256)
    else $error("lit count out of range");

  // The refresh sequence closes with a no-op group
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_group_end && out_last |-> out_serial_word == 16'h0000)
    else $error("refresh does not end with a no-op");

  // Refresh words report no old pixel
  a_old: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_serial_word != 16'h0000 |-> !out_old_pixel)
    else $error("old pixel set on a refresh word");

  // Inside a refresh, a word other than a no-op is never last
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_serial_word != 16'h0000 |-> !out_last)
    else $error("refresh ended early");

endmodule

bind led_matrix_framebuffer_refresh lmf_checker u_lmf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_old_pixel   (out_chan.old_pixel),
  .out_lit_count   (out_chan.lit_count),
  .out_serial_word (out_chan.serial_word),
  .out_group_end   (out_chan.group_end),
  .out_last        (out_chan.last)
);
